@@ hw/rtl/spq_pkg.sv @@
// ============================================================================
// spq_pkg: shared types and constants for the stable priority queue
// Holds the queue depth, the command and status codes and the cell types.
// ============================================================================
`default_nettype none

package spq_pkg;

  // Number of cells in the chain, one queue entry per cell.
  localparam int CAPACITY = 16;
  // Width of the entry count, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Result status codes carried on the output tuser.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NEG_PRIO = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // One queue entry.
  typedef struct packed {
    logic signed [7:0] floor_number;
    logic [6:0]        priority_level;
  } slot_t;

  // Operation broadcast from the control logic to every cell.
  typedef struct packed {
    logic  insert_en;
    logic  pop_en;
    slot_t new_slot;
    logic signed [7:0] query_floor;
  } bcast_t;

endpackage

`default_nettype wire

@@ hw/rtl/spq_cell.sv @@
// ============================================================================
// spq_cell: one entry of the sorted shift-register queue
// Holds a floor and priority, compares them with the broadcast operation and
// takes the new entry, its left neighbor or its right neighbor.
// ============================================================================
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic   clk,
  input  wire bcast_t bcast,
  input  wire logic   occupied,
  input  wire logic   ge_left,
  input  wire slot_t  left_slot,
  input  wire slot_t  right_slot,
  output logic        ge,
  output logic        match,
  output slot_t       slot
);

  // An occupied entry with priority at least the new one stays in front of it.
  assign ge = occupied && (slot.priority_level >= bcast.new_slot.priority_level);

  // Query hit on this entry.
  assign match = occupied && (slot.floor_number == bcast.query_floor);

  // On insert, the first cell not ahead of the new entry takes it and the
  // cells behind shift right; on pop every cell takes its right neighbor.
  always_ff @(posedge clk) begin
    if (bcast.insert_en) begin
      if (!ge) begin
        slot <= ge_left ? bcast.new_slot : left_slot;
      end
    end else if (bcast.pop_en) begin
      slot <= right_slot;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stable_priority_queue_core.sv @@
// ============================================================================
// stable_priority_queue_core: sorted priority queue of floor requests
// Chain of cells kept sorted by priority with a one-word output register.
// ============================================================================
// For every word, all cells compare against the incoming operation in
// parallel and shift in the same cycle, and the result is held in an
// output register, so a new word is accepted each cycle while the output
// side takes results. Up to CAPACITY entries are held; equal priorities
// leave in arrival order. The queue needs no clearing after reset.
`default_nettype none

module stable_priority_queue_core
  import spq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] floor_number, [15:8] request_priority
  input  wire logic [15:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] popped_floor, [14:8] popped_priority, [15] found,
  // [20:16] entry_total, [23:21] zero
  output logic [23:0]      m_tdata,
  // [1:0] status
  output logic [1:0]       m_tuser
);

  logic             accept;
  cmd_t             cmd;
  logic signed [7:0] in_floor;
  logic signed [7:0] in_prio;
  logic [CNT_W-1:0] occupancy;
  logic [CNT_W-1:0] occupancy_next;
  bcast_t           bcast;
  status_t          status_next;
  status_t          status;
  logic [7:0]       popped_floor;
  logic [6:0]       popped_priority;
  logic             found;
  logic [4:0]       entry_total;

  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] match_vec;
  slot_t               slots [CAPACITY];

  assign cmd      = cmd_t'(s_tuser);
  assign in_floor = s_tdata[7:0];
  assign in_prio  = s_tdata[15:8];

  // Input side stays open while the output register is empty or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Decode the operation and its status.
  always_comb begin
    bcast.insert_en    = 1'b0;
    bcast.pop_en       = 1'b0;
    bcast.new_slot.floor_number   = in_floor;
    bcast.new_slot.priority_level = in_prio[6:0];
    bcast.query_floor  = in_floor;
    status_next        = STAT_OK;
    occupancy_next     = occupancy;
    unique case (cmd)
      CMD_INSERT: begin
        if (in_prio[7]) begin
          status_next = STAT_NEG_PRIO;
        end else if (occupancy == CNT_W'(CAPACITY)) begin
          status_next = STAT_FULL;
        end else begin
          bcast.insert_en = accept;
          occupancy_next  = occupancy + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (occupancy == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          bcast.pop_en   = accept;
          occupancy_next = occupancy - CNT_W'(1);
        end
      end
      CMD_QUERY: begin
        status_next = STAT_OK;
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
  end

  // The chain of cells; the head cell sees a boundary on its left.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  occ;
    logic  ge_l;
    slot_t left_s;
    slot_t right_s;

    assign occ = (CNT_W'(i) < occupancy);

    if (i == 0) begin : g_head
      assign ge_l   = 1'b1;
      assign left_s = bcast.new_slot;
    end else begin : g_body
      assign ge_l   = ge_vec[i-1];
      assign left_s = slots[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .bcast      (bcast),
      .occupied   (occ),
      .ge_left    (ge_l),
      .left_slot  (left_s),
      .right_slot (right_s),
      .ge         (ge_vec[i]),
      .match      (match_vec[i]),
      .slot       (slots[i])
    );
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept) begin
      occupancy <= occupancy_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload, captured with the accepted word.
  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= status_next;
      popped_floor    <= bcast.pop_en ? slots[0].floor_number : 8'd0;
      popped_priority <= bcast.pop_en ? slots[0].priority_level : 7'd0;
      found           <= (cmd == CMD_QUERY) && (|match_vec);
      entry_total     <= 5'(occupancy_next);
    end
  end

  assign m_tuser = status;
  assign m_tdata = {3'b000, entry_total, found, popped_priority, popped_floor};

endmodule

`default_nettype wire

@@ hw/rtl/stable_priority_queue_core_checker.sv @@
// ============================================================================
// stable_priority_queue_core_checker: port-level checks for the queue
// Watches the top-level ports and is bound to every instance of the core.
// ============================================================================
`default_nettype none

module stable_priority_queue_core_checker
  import spq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // A stalled result word holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // Every accepted word yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

  // A pop on an empty queue reports an empty queue.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_EMPTY) |-> (m_tdata[20:16] == 5'd0))
    else $error("empty status with nonzero count");

  // A rejected full insert reports a full queue.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata[20:16] == 5'(CAPACITY)))
    else $error("full status with count below capacity");

endmodule

bind stable_priority_queue_core stable_priority_queue_core_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ bench/spq_checker.sv @@
// ============================================================================
// spq_checker: result checker for the stable priority queue
// Watches both stream channels and keeps its own copy of the sorted queue.
// Every accepted input word is applied to that copy, and the outcome is queued.
// Every accepted output word is compared field by field with the oldest
// outcome in that queue.
// ============================================================================

module spq_checker
  import spq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  // [7:0] floor_number, [15:8] request_priority
  input  wire logic [15:0] s_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  // [7:0] popped_floor, [14:8] popped_priority, [15] found, [20:16] entry_total
  input  wire logic [23:0] m_tdata,
  // [1:0] status
  input  wire logic [1:0]  m_tuser,
  output int               fail_count,
  output int               owed_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Outcome of one operation, as the output word should carry it.
  typedef struct {
    status_t           status;
    logic signed [7:0] popped_floor;
    logic [6:0]        popped_priority;
    logic              found;
    logic [CNT_W-1:0]  entry_total;
  } queue_result_t;

  // Shadow copy of the queue, head in slot 0.
  slot_t         shadow_slots [CAPACITY];
  int            shadow_count;
  queue_result_t owed_results [$];
  queue_result_t want;

  // Apply one operation to the shadow queue and return what the block owes.
  function automatic queue_result_t apply_request(cmd_t cmd, logic signed [7:0] fl,
                                                  logic signed [7:0] pr);
    queue_result_t res;
    int pos;
    int i;
    res.status          = STAT_OK;
    res.popped_floor    = '0;
    res.popped_priority = '0;
    res.found           = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        // A negative priority is rejected before fullness is looked at.
        if (pr[7]) begin
          res.status = STAT_NEG_PRIO;
        end else if (shadow_count >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          // Go behind every entry of equal or higher priority.
          pos = 0;
          while (pos < shadow_count && shadow_slots[pos].priority_level >= pr[6:0])
            pos++;
          for (i = shadow_count; i > pos; i--)
            shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[pos].floor_number   = fl;
          shadow_slots[pos].priority_level = pr[6:0];
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.popped_floor    = shadow_slots[0].floor_number;
          res.popped_priority = shadow_slots[0].priority_level;
          for (i = 1; i < shadow_count; i++)
            shadow_slots[i-1] = shadow_slots[i];
          shadow_count--;
        end
      end
      CMD_QUERY: begin
        for (i = 0; i < shadow_count; i++)
          if (shadow_slots[i].floor_number == fl)
            res.found = 1'b1;
      end
      default: begin
        // The spare code does nothing.
      end
    endcase
    res.entry_total = shadow_count[CNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Compare before predicting: a result never answers the word accepted at
  // the same edge, since the block registers its output.
  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      owed_results.delete();
      fail_count   = 0;
      owed_count   = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          $error("result word with nothing owed: tdata %h, tuser %h", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", 8'(want.status), 8'(m_tuser));
          check_field("popped_floor", want.popped_floor, m_tdata[7:0]);
          check_field("popped_priority", 8'(want.popped_priority), 8'(m_tdata[14:8]));
          check_field("found", 8'(want.found), 8'(m_tdata[15]));
          check_field("entry_total", 8'(want.entry_total), 8'(m_tdata[20:16]));
        end
      end
      if (s_tvalid && s_tready)
        owed_results.push_back(apply_request(cmd_t'(s_tuser), s_tdata[7:0],
                                             s_tdata[15:8]));
      owed_count = owed_results.size();
    end
  end

endmodule

@@ bench/tb_top.sv @@
// ============================================================================
// tb_top: testbench for stable_priority_queue_core
// Drives insert, pop and query words with random gaps on both sides, while
// the checker beside the block predicts and compares every result word.
// ============================================================================

module tb_top
  import spq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_WORDS = 900;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  int fail_count;
  int owed_count;
  int stall_cycles = 0;
  bit gaps_on = 1'b1;

  always #5 clk = ~clk;

  stable_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  spq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  // The output side holds off at random while gaps are enabled.
  always @(negedge clk) begin
    m_tready <= !gaps_on || ($urandom_range(99) >= 26);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Offer one word, with an optional random gap before it, and hold it until
  // it is taken. Returns at the falling edge after the accepting edge.
  task automatic send_word(cmd_t cmd, logic [7:0] fl, logic [7:0] pr);
    if (gaps_on) begin
      while ($urandom_range(99) < 26) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {pr, fl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (owed_count != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    int mode;
    int r;
    int p;
    logic [7:0] fl;
    logic [7:0] pr;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: empty queue cases, rejects, ties, a full queue.
    send_word(CMD_POP, 8'h5a, 8'ha5);
    send_word(CMD_QUERY, 8'h00, 8'hff);
    send_word(CMD_NOP, 8'hff, 8'hff);
    send_word(CMD_INSERT, 8'h7f, 8'h80);
    send_word(CMD_INSERT, 8'h80, 8'hff);
    for (n = 0; n < CAPACITY; n++) begin
      case (n % 4)
        0: pr = 8'd0;
        1: pr = 8'd127;
        2: pr = 8'd64;
        default: pr = 8'(n);
      endcase
      send_word(CMD_INSERT, 8'(n * 17 - 128), pr);
    end
    send_word(CMD_INSERT, 8'h11, 8'd50);
    send_word(CMD_INSERT, 8'h22, 8'h81);
    send_word(CMD_QUERY, 8'h80, 8'h00);
    send_word(CMD_QUERY, 8'h7e, 8'h00);
    send_word(CMD_POP, 8'h00, 8'h00);

    // Let every directed result come out before the random part.
    wait_drained();

    // Random part: blocks that lean toward filling, draining or a balance.
    mode = 0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) mode = $urandom_range(2);
      gaps_on = !(n >= 300 && n < 450);
      if (n % 170 == 169) wait_drained();

      r  = $urandom_range(99);
      fl = $urandom_range(99) < 50 ? 8'($urandom_range(7) - 4) : 8'($urandom_range(255));
      pr = 8'($urandom_range(255));
      if (r < (mode == 0 ? 70 : mode == 1 ? 25 : 40)) begin
        p = $urandom_range(99);
        if (p < 10)
          pr = 8'($urandom_range(255, 128));
        else if (p < 50)
          pr = 8'($urandom_range(3));
        else
          pr = 8'($urandom_range(127));
        send_word(CMD_INSERT, fl, pr);
      end else if (r < (mode == 2 ? 75 : 85)) begin
        send_word(CMD_POP, fl, pr);
      end else if (r < 97) begin
        send_word(CMD_QUERY, fl, pr);
      end else begin
        send_word(CMD_NOP, fl, pr);
      end
    end

    // Drain, then watch a little longer for stray result words.
    gaps_on = 1'b1;
    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
